[hdl/slfr_pkg.sv]
package slfr_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_FIRST_SYNC  = 2'd0;
  localparam logic [1:0] CFG_SECOND_SYNC = 2'd1;
  localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

  // Register reset values
  localparam logic [7:0] FIRST_SYNC_RESET  = 8'h55;
  localparam logic [7:0] SECOND_SYNC_RESET = 8'haa;
  localparam logic [8:0] MAX_PAYLOAD_RESET = 9'd256;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  // Default depth of the result queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] command;
    logic [8:0] frame_length;
    logic       last;
  } result_t;

endpackage

[hdl/sync_length_frame_receiver_top.sv]
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata[7:0]   = rx_byte
// m_        out  m_tvalid/m_tready    m_tdata, m_tuser = kind, m_tlast = last
// cfg_      in   cfg_we               cfg_index, cfg_data
//
// Takes one word per cycle while the result queue is not full; each result is
// held in the result queue and then registered in the output register.
// Synchronous active-high rst restores the sync bytes and length limit to
// their defaults, returns the parser to sync hunting and empties the queue.
// s_tready drops only while the result queue is full; a stalled output side
// fills the queue and the output register before the input side waits.
module sync_length_frame_receiver_top #(
  parameter int QUEUE_DEPTH = slfr_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] payload_byte, [15:8] command,
                                 // [24:16] frame_length, [31:25] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  logic              push;
  slfr_pkg::result_t push_item;
  logic              q_full;
  logic              pop;
  logic              q_valid;
  slfr_pkg::result_t q_item;

  // Front: hold the configuration, parse each byte, classify it
  slfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Queue: decouple parsing from output stalls
  slfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // Back: register and pack results onto the output stream
  slfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[hdl/slfr_front.sv]
module slfr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [8:0]          cfg_data,
  input  logic                q_full,
  output logic                push,
  output slfr_pkg::result_t   push_item
);

  localparam logic [2:0] PH_SYNC1   = 3'd0;
  localparam logic [2:0] PH_SYNC2   = 3'd1;
  localparam logic [2:0] PH_VERSION = 3'd2;
  localparam logic [2:0] PH_COMMAND = 3'd3;
  localparam logic [2:0] PH_LEN_HI  = 3'd4;
  localparam logic [2:0] PH_LEN_LO  = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_CHECK   = 3'd7;

  logic [7:0] first_sync;
  logic [7:0] second_sync;
  logic [8:0] max_payload;

  logic [2:0] phase, phase_next;
  logic [7:0] length_high, length_high_next;
  logic [8:0] remaining, remaining_next;
  logic [8:0] payload_count, payload_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] frame_command, frame_command_next;

  logic        accept;
  logic        emit;
  logic [15:0] len_word;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && emit;
  assign len_word = {length_high, s_tdata};

  always_comb begin
    phase_next         = phase;
    length_high_next   = length_high;
    remaining_next     = remaining;
    payload_count_next = payload_count;
    running_sum_next   = running_sum + s_tdata;
    frame_command_next = frame_command;
    emit               = 1'b0;
    push_item.kind         = slfr_pkg::KIND_PAYLOAD;
    push_item.payload_byte = s_tdata;
    push_item.command      = frame_command;
    push_item.frame_length = payload_count + remaining;
    push_item.last         = 1'b0;
    unique case (phase)
      PH_SYNC1: begin
        running_sum_next = running_sum;
        if (s_tdata == first_sync) begin
          running_sum_next = s_tdata;
          phase_next       = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (s_tdata == second_sync) begin
          phase_next = PH_VERSION;
        end else begin
          running_sum_next = running_sum;
          phase_next       = PH_SYNC1;
        end
      end
      PH_VERSION: phase_next = PH_COMMAND;
      PH_COMMAND: begin
        frame_command_next = s_tdata;
        phase_next         = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_high_next = s_tdata;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        // drop oversized frames and hunt again
        if (len_word > {7'd0, max_payload}) begin
          phase_next = PH_SYNC1;
        end else begin
          remaining_next     = len_word[8:0];
          payload_count_next = 9'd0;
          phase_next         = (len_word[8:0] == 9'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        emit               = 1'b1;
        payload_count_next = payload_count + 9'd1;
        remaining_next     = remaining - 9'd1;
        if (remaining == 9'd1) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        emit                   = 1'b1;
        running_sum_next       = running_sum;
        push_item.kind         = (s_tdata == running_sum) ? slfr_pkg::KIND_GOOD
                                                          : slfr_pkg::KIND_BAD;
        push_item.payload_byte = 8'd0;
        push_item.frame_length = payload_count;
        push_item.last         = 1'b1;
        phase_next             = PH_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync    <= slfr_pkg::FIRST_SYNC_RESET;
      second_sync   <= slfr_pkg::SECOND_SYNC_RESET;
      max_payload   <= slfr_pkg::MAX_PAYLOAD_RESET;
      phase         <= PH_SYNC1;
      length_high   <= 8'd0;
      remaining     <= 9'd0;
      payload_count <= 9'd0;
      running_sum   <= 8'd0;
      frame_command <= 8'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          slfr_pkg::CFG_FIRST_SYNC:  first_sync  <= cfg_data[7:0];
          slfr_pkg::CFG_SECOND_SYNC: second_sync <= cfg_data[7:0];
          slfr_pkg::CFG_MAX_PAYLOAD: max_payload <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        phase         <= phase_next;
        length_high   <= length_high_next;
        remaining     <= remaining_next;
        payload_count <= payload_count_next;
        running_sum   <= running_sum_next;
        frame_command <= frame_command_next;
      end
    end
  end

endmodule

[hdl/slfr_queue.sv]
module slfr_queue #(
  parameter int DEPTH = slfr_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  slfr_pkg::result_t   push_item,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output slfr_pkg::result_t   q_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  slfr_pkg::result_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");
`endif

endmodule

[hdl/slfr_back.sv]
module slfr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  slfr_pkg::result_t   q_item,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,
  output logic [1:0]          m_tuser,
  output logic                m_tlast
);

  logic              out_valid;
  slfr_pkg::result_t out_item;

  // refill the output register when it is empty or being taken
  assign pop      = q_valid && (!out_valid || m_tready);
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_item.frame_length, out_item.command, out_item.payload_byte};
  assign m_tuser  = out_item.kind;
  assign m_tlast  = out_item.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= q_item;
    end
  end

`ifndef SYNTH
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser != slfr_pkg::KIND_PAYLOAD)))
    else $error("tlast disagrees with kind");

  a_end_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[7:0] == 8'd0))
    else $error("frame end word carries a payload byte");

  a_fill_after_pop: assert property (@(posedge clk) disable iff (rst)
    pop |=> m_tvalid)
    else $error("output register empty after a pop");
`endif

endmodule
